### design/hrhp_pkg.sv
`default_nettype none
package hrhp_pkg;

  // target counter width and register width of the length limit
  localparam int TARGET_COUNT_BITS = 16;
  localparam int LIMIT_BITS        = 16;
  localparam int CMP_W = ((TARGET_COUNT_BITS > LIMIT_BITS) ? TARGET_COUNT_BITS : LIMIT_BITS) + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // parse phases
  localparam logic [3:0] PH_METHOD = 4'd0;
  localparam logic [3:0] PH_TARGET = 4'd1;
  localparam logic [3:0] PH_PROTO  = 4'd2;
  localparam logic [3:0] PH_LSTART = 4'd3;
  localparam logic [3:0] PH_HNAME  = 4'd4;
  localparam logic [3:0] PH_HOWS   = 4'd5;
  localparam logic [3:0] PH_HVALUE = 4'd6;
  localparam logic [3:0] PH_HSKIP  = 4'd7;
  localparam logic [3:0] PH_HLF    = 4'd8;
  localparam logic [3:0] PH_ENDLF  = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;

  // status codes
  localparam logic [2:0] ST_RUN        = 3'd0;
  localparam logic [2:0] ST_OK         = 3'd1;
  localparam logic [2:0] ST_BAD        = 3'd2;
  localparam logic [2:0] ST_NOTIMPL    = 3'd3;
  localparam logic [2:0] ST_LONG       = 3'd4;
  localparam logic [2:0] ST_VERSION    = 3'd5;
  localparam logic [2:0] ST_INCOMPLETE = 3'd6;

  // byte classes
  localparam logic [2:0] CL_METHOD = 3'd0;
  localparam logic [2:0] CL_TARGET = 3'd1;
  localparam logic [2:0] CL_PROTO  = 3'd2;
  localparam logic [2:0] CL_NAME   = 3'd3;
  localparam logic [2:0] CL_VALUE  = 3'd4;
  localparam logic [2:0] CL_DELIM  = 3'd5;

  // method codes
  localparam logic [1:0] MC_NONE = 2'd0;
  localparam logic [1:0] MC_GET  = 2'd1;
  localparam logic [1:0] MC_HEAD = 2'd2;
  localparam logic [1:0] MC_POST = 2'd3;

  // register addresses
  localparam logic [1:0] ADDR_MAX_TARGET_LEN = 2'd0;
  localparam logic [LIMIT_BITS-1:0] MAX_TARGET_LEN_RESET = 16'd2048;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] lower;
    logic       first;
    logic       last;
    logic       is_sp;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
  } hrhp_item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } hrhp_qstat_t;

  // m is the method index (GET, HEAD, POST), p the position within its text
  function automatic logic [7:0] method_char(input logic [1:0] m, input logic [2:0] p);
    logic [7:0] c;
    c = 8'h00;
    unique case (m)
      2'd0: begin
        unique case (p)
          3'd0: c = "G";
          3'd1: c = "E";
          3'd2: c = "T";
          3'd3: c = " ";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (p)
          3'd0: c = "H";
          3'd1: c = "E";
          3'd2: c = "A";
          3'd3: c = "D";
          3'd4: c = " ";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (p)
          3'd0: c = "P";
          3'd1: c = "O";
          3'd2: c = "S";
          3'd3: c = "T";
          3'd4: c = " ";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] method_len(input logic [1:0] m);
    return (m == 2'd0) ? 5'd4 : 5'd5;
  endfunction

  function automatic logic [7:0] proto_char(input logic [3:0] p);
    logic [7:0] c;
    c = 8'h00;
    unique case (p)
      4'd0: c = "H";
      4'd1: c = "T";
      4'd2: c = "T";
      4'd3: c = "P";
      4'd4: c = "/";
      4'd5: c = "1";
      4'd6: c = ".";
      4'd7: c = "1";
      4'd8: c = CH_CR;
      4'd9: c = CH_LF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### design/http_request_head_parser.sv
`default_nettype none
// Channel   Direction  Payload
// in_       slave      tdata[7:0] data_byte, tuser first_byte, tlast last_byte
// out_      master     tdata byte_out, byte_class, method_code, status; tlast head_done
// cfg_      APB slave  0x0 max_target_len[15:0]
//
// One byte per cycle sustained while out_tready is high; each byte is registered
// in the queue after the classifier, then in the output register by the parser.
// The parser state updates on each popped byte; throughput is set by that loop.
// A two-entry queue between classifier and parser lets either side stall alone;
// in_tready drops only when the queue is full.
// Synchronous active-low reset clears queue and parser, sets the limit to 2048.
module http_request_head_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] first_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] byte_out, [10:8] byte_class,
                                       // [12:11] method_code, [15:13] status
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import hrhp_pkg::*;

  logic [LIMIT_BITS-1:0] max_len_r;
  hrhp_item_t            push_item, head_item;
  hrhp_qstat_t           qstat;
  logic                  push, pop;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_MAX_TARGET_LEN) ? {16'd0, max_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_TARGET_LEN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr == ADDR_MAX_TARGET_LEN)) begin
      max_len_r <= cfg_pwdata[LIMIT_BITS-1:0];
    end
  end

  hrhp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (qstat.full),
    .in_tready (in_tready),
    .push      (push),
    .item      (push_item)
  );

  hrhp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (qstat)
  );

  hrhp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (head_item),
    .item_valid     (!qstat.empty),
    .max_target_len (max_len_r),
    .pop            (pop),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast)
  );

  a_qcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!qstat.empty && !out_tvalid) |=> out_tvalid)
    else $error("queued byte not moved to output");

  a_done_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[15:13] != ST_RUN))
    else $error("head end without final status");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (qstat.full && !pop) |=> !qstat.empty)
    else $error("full queue lost an entry");

endmodule
`default_nettype wire

### design/hrhp_front.sv
`default_nettype none
module hrhp_front (
  input  wire logic              in_tvalid,
  input  wire logic [7:0]        in_tdata,
  input  wire logic              in_tuser,
  input  wire logic              in_tlast,
  input  wire logic              q_full,
  output logic                   in_tready,
  output logic                   push,
  output hrhp_pkg::hrhp_item_t   item
);
  import hrhp_pkg::*;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    item.raw      = in_tdata;
    item.lower    = ((in_tdata >= 8'h41) && (in_tdata <= 8'h5a)) ? (in_tdata + 8'h20) : in_tdata;
    item.first    = in_tuser;
    item.last     = in_tlast;
    item.is_sp    = (in_tdata == CH_SP);
    item.is_cr    = (in_tdata == CH_CR);
    item.is_lf    = (in_tdata == CH_LF);
    item.is_colon = (in_tdata == CH_COLON);
  end

endmodule
`default_nettype wire

### design/hrhp_queue.sv
`default_nettype none
module hrhp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire hrhp_pkg::hrhp_item_t push_item,
  input  wire logic                 pop,
  output hrhp_pkg::hrhp_item_t      head_item,
  output hrhp_pkg::hrhp_qstat_t     stat
);
  import hrhp_pkg::*;

  hrhp_item_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;
  assign head_item  = mem_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

### design/hrhp_back.sv
`default_nettype none
module hrhp_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire hrhp_pkg::hrhp_item_t              item,
  input  wire logic                              item_valid,
  input  wire logic [hrhp_pkg::LIMIT_BITS-1:0]   max_target_len,
  output logic                                   pop,
  input  wire logic                              out_tready,
  output logic                                   out_tvalid,
  output logic [15:0]                            out_tdata,
  output logic                                   out_tlast
);
  import hrhp_pkg::*;

  logic [3:0]                   phase_r, phase_nxt;
  logic [3:0]                   pos_r, pos_nxt;
  logic [1:0]                   meth_r, meth_nxt;
  logic [TARGET_COUNT_BITS-1:0] tlen_r, tlen_nxt;
  logic [2:0]                   fstat_r, fstat_nxt;

  logic                         out_valid_r;
  logic [15:0]                  out_data_r;
  logic                         out_last_r;

  logic [3:0]                   ph_c, pos_c;
  logic [1:0]                   meth_c, m_idx;
  logic [TARGET_COUNT_BITS-1:0] tlen_c;
  logic [2:0]                   fst_c;
  logic                         was_done, done;
  logic [2:0]                   cls, res_status;
  logic [1:0]                   res_method;
  logic [7:0]                   outb;
  logic [TARGET_COUNT_BITS:0]   tl_inc;
  logic                         too_long;
  logic [4:0]                   pos_inc;

  // advance the parser when a byte is queued and the output is free or draining
  assign pop = item_valid && (!out_valid_r || out_tready);

  assign m_idx    = meth_c - 2'd1;
  assign pos_inc  = {1'b0, pos_c} + 5'd1;
  assign tl_inc   = {1'b0, tlen_c} + {{TARGET_COUNT_BITS{1'b0}}, 1'b1};
  assign too_long = (CMP_W'(tl_inc) > CMP_W'(max_target_len)) || (&tlen_c);

  always_comb begin
    // a first byte restarts the parse before it is looked at
    ph_c   = item.first ? PH_METHOD : phase_r;
    pos_c  = item.first ? 4'd0      : pos_r;
    meth_c = item.first ? MC_NONE   : meth_r;
    tlen_c = item.first ? '0        : tlen_r;
    fst_c  = item.first ? ST_RUN    : fstat_r;

    phase_nxt = ph_c;
    pos_nxt   = pos_c;
    meth_nxt  = meth_c;
    tlen_nxt  = tlen_c;
    fstat_nxt = fst_c;
    cls       = CL_DELIM;
    outb      = item.raw;
    done      = 1'b0;
    was_done  = (ph_c >= PH_DONE);

    if (!was_done) begin
      unique case (ph_c)
        PH_METHOD: begin
          if (pos_c == 4'd0) begin
            if (item.raw == "G") begin
              meth_nxt = MC_GET;
            end else if (item.raw == "H") begin
              meth_nxt = MC_HEAD;
            end else if (item.raw == "P") begin
              meth_nxt = MC_POST;
            end else begin
              meth_nxt = MC_NONE;
            end
            if (meth_nxt == MC_NONE) begin
              fstat_nxt = ST_NOTIMPL;
              phase_nxt = PH_DONE;
            end else begin
              cls     = CL_METHOD;
              pos_nxt = 4'd1;
            end
          end else if ((m_idx == 2'd3) || (pos_c > 4'd4)
                       || (item.raw != method_char(m_idx, pos_c[2:0]))) begin
            meth_nxt  = MC_NONE;
            fstat_nxt = ST_NOTIMPL;
            phase_nxt = PH_DONE;
          end else if (pos_inc >= method_len(m_idx)) begin
            phase_nxt = PH_TARGET;
            pos_nxt   = 4'd0;
          end else begin
            cls     = CL_METHOD;
            pos_nxt = pos_inc[3:0];
          end
        end
        PH_TARGET: begin
          if (item.is_sp) begin
            if (tlen_c == '0) begin
              fstat_nxt = ST_BAD;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_PROTO;
              pos_nxt   = 4'd0;
            end
          end else if (too_long) begin
            fstat_nxt = ST_LONG;
            phase_nxt = PH_DONE;
          end else begin
            tlen_nxt = tl_inc[TARGET_COUNT_BITS-1:0];
            cls      = CL_TARGET;
          end
        end
        PH_PROTO: begin
          if ((pos_c > 4'd9) || (item.raw != proto_char(pos_c))) begin
            fstat_nxt = ST_VERSION;
            phase_nxt = PH_DONE;
          end else begin
            cls = (pos_c < 4'd8) ? CL_PROTO : CL_DELIM;
            if (pos_c == 4'd9) begin
              phase_nxt = PH_LSTART;
              pos_nxt   = 4'd0;
            end else begin
              pos_nxt = pos_inc[3:0];
            end
          end
        end
        PH_LSTART: begin
          if (item.is_cr) begin
            phase_nxt = PH_ENDLF;
          end else if (item.is_colon) begin
            phase_nxt = PH_HOWS;
          end else begin
            cls       = CL_NAME;
            outb      = item.lower;
            phase_nxt = PH_HNAME;
          end
        end
        PH_HNAME: begin
          if (item.is_cr) begin
            fstat_nxt = ST_BAD;
            phase_nxt = PH_DONE;
          end else if (item.is_colon) begin
            phase_nxt = PH_HOWS;
          end else begin
            cls  = CL_NAME;
            outb = item.lower;
          end
        end
        PH_HOWS, PH_HVALUE: begin
          if (item.is_cr) begin
            phase_nxt = PH_HLF;
          end else if (item.is_sp) begin
            if (ph_c == PH_HVALUE) begin
              phase_nxt = PH_HSKIP;
            end
          end else begin
            cls       = CL_VALUE;
            outb      = item.lower;
            phase_nxt = PH_HVALUE;
          end
        end
        PH_HSKIP: begin
          if (item.is_cr) begin
            phase_nxt = PH_HLF;
          end
        end
        PH_HLF: begin
          if (item.is_lf) begin
            phase_nxt = PH_LSTART;
          end else begin
            fstat_nxt = ST_BAD;
            phase_nxt = PH_DONE;
          end
        end
        PH_ENDLF: begin
          fstat_nxt = item.is_lf ? ST_OK : ST_BAD;
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase

      if (phase_nxt == PH_DONE) begin
        done = 1'b1;
      end else if (item.last) begin
        // message ran out before the head ended
        unique case (phase_nxt)
          PH_METHOD: fstat_nxt = ST_BAD;
          PH_TARGET: fstat_nxt = (tlen_nxt == '0) ? ST_INCOMPLETE : ST_BAD;
          PH_PROTO:  fstat_nxt = ST_VERSION;
          PH_ENDLF:  fstat_nxt = ST_BAD;
          default:   fstat_nxt = ST_INCOMPLETE;
        endcase
        if (phase_nxt == PH_METHOD) begin
          meth_nxt = MC_NONE;
        end
        phase_nxt = PH_DONE;
        done      = 1'b1;
      end
    end

    res_method = (phase_nxt == PH_METHOD) ? MC_NONE : meth_nxt;
    res_status = (was_done || done) ? fstat_nxt : ST_RUN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_METHOD;
      pos_r       <= 4'd0;
      meth_r      <= MC_NONE;
      tlen_r      <= '0;
      fstat_r     <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        meth_r  <= meth_nxt;
        tlen_r  <= tlen_nxt;
        fstat_r <= fstat_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= {res_status, res_method, cls, outb};
      out_last_r <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
